/* rtl/core/pgdh_pkg.sv */
`timescale 1ns / 1ps
package pgdh_pkg;

  localparam int POS_W     = 32;
  localparam int SCALE_W   = 24;
  localparam int BINS_W    = 6;
  localparam int TIME_W    = 32;
  localparam int FRAC_W    = 32;
  localparam int RADDR_W   = 15;
  localparam int FRAMES_W  = 24;
  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [FRAMES_W-1:0] FRAME_MAX = '1;
  localparam logic [SCALE_W-1:0]  SCALE_RST = 24'h01_0000;
  localparam logic [BINS_W-1:0]   BINS_RST  = 6'd1;

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_ATOM   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_SCALE_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BINS_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BINS_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BINS_Z  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WIN_LO  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_WIN_HI  = 3'd7;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [SCALE_W-1:0] scale_z;
    logic [BINS_W-1:0]  bins_x;
    logic [BINS_W-1:0]  bins_y;
    logic [BINS_W-1:0]  bins_z;
    logic [TIME_W-1:0]  window_start;
    logic [TIME_W-1:0]  window_end;
  } cfg_t;

  // request travelling alongside the datapath
  typedef struct packed {
    logic                valid;
    logic                is_read;
    logic                in_range;
    logic [RADDR_W-1:0]  raddr;
    logic [FRAMES_W-1:0] frames;
    logic                closed;
  } side_t;

endpackage

/* rtl/core/pgdh_regs.sv */
`timescale 1ns / 1ps
module pgdh_regs import pgdh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x      <= SCALE_RST;
      cfg.scale_y      <= SCALE_RST;
      cfg.scale_z      <= SCALE_RST;
      cfg.bins_x       <= BINS_RST;
      cfg.bins_y       <= BINS_RST;
      cfg.bins_z       <= BINS_RST;
      cfg.window_start <= '0;
      cfg.window_end   <= '0;
    end else if (wr) begin
      case (idx)
        REG_SCALE_X: cfg.scale_x      <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y: cfg.scale_y      <= pwdata[SCALE_W-1:0];
        REG_SCALE_Z: cfg.scale_z      <= pwdata[SCALE_W-1:0];
        REG_BINS_X:  cfg.bins_x       <= pwdata[BINS_W-1:0];
        REG_BINS_Y:  cfg.bins_y       <= pwdata[BINS_W-1:0];
        REG_BINS_Z:  cfg.bins_z       <= pwdata[BINS_W-1:0];
        REG_WIN_LO:  cfg.window_start <= pwdata[TIME_W-1:0];
        REG_WIN_HI:  cfg.window_end   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCALE_X: prdata = 32'(cfg.scale_x);
      REG_SCALE_Y: prdata = 32'(cfg.scale_y);
      REG_SCALE_Z: prdata = 32'(cfg.scale_z);
      REG_BINS_X:  prdata = 32'(cfg.bins_x);
      REG_BINS_Y:  prdata = 32'(cfg.bins_y);
      REG_BINS_Z:  prdata = 32'(cfg.bins_z);
      REG_WIN_LO:  prdata = cfg.window_start;
      REG_WIN_HI:  prdata = cfg.window_end;
      default:     prdata = '0;
    endcase
  end

endmodule

/* rtl/core/pgdh_axis.sv */
`timescale 1ns / 1ps
module pgdh_axis import pgdh_pkg::*; #(
  parameter  int MAX_BINS_PER_AXIS = 32,
  localparam int NW = $clog2(MAX_BINS_PER_AXIS + 1),
  localparam int IW = (MAX_BINS_PER_AXIS > 1) ? $clog2(MAX_BINS_PER_AXIS) : 1
) (
  input  logic                      clk,
  input  logic signed [POS_W-1:0]   pos,
  input  logic        [SCALE_W-1:0] scale,
  input  logic        [NW-1:0]      n,
  output logic        [IW-1:0]      idx
);

  localparam int PW  = POS_W + SCALE_W + 1;
  localparam int FLW = PW - 1 - FRAC_W;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] span;
  logic signed [PW-1:0] wrap_next;
  logic signed [PW-1:0] wrapped;
  logic        [FLW-1:0] fl;
  logic        [IW-1:0]  idx_next;

  // bin units in Q.32
  always_ff @(posedge clk) begin
    prod <= pos * $signed({1'b0, scale});
  end

  assign span = $signed(PW'(n) << FRAC_W);

  // single periodic wrap
  always_comb begin
    if (prod >= span) begin
      wrap_next = prod - span;
    end else if (prod[PW-1]) begin
      wrap_next = prod + span;
    end else begin
      wrap_next = prod;
    end
  end

  always_ff @(posedge clk) begin
    wrapped <= wrap_next;
  end

  assign fl = wrapped[PW-2:FRAC_W];

  always_comb begin
    if (wrapped[PW-1]) begin
      idx_next = '0;
    end else if (32'(fl) >= 32'(n)) begin
      idx_next = IW'(n - NW'(1));
    end else begin
      idx_next = IW'(fl);
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

endmodule

/* rtl/core/pgdh_bin_ram.sv */
`timescale 1ns / 1ps
module pgdh_bin_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/periodic_grid_density_histogram.sv */
`timescale 1ns / 1ps
// 3-d periodic grid histogram. one request is taken per clock while busy is low; frame header
// and atom requests give no result, a read request gives one result, strobed on done for one
// cycle, in request order. busy is high only for the clearing pass after reset, which writes
// every bin of the single-port-write count memory once: MAX_BINS_PER_AXIS cubed bins (32768
// with the defaults). an atom's bin is read from the count memory, incremented and written back
// in the following cycle; a repeated bin on consecutive atoms is served from the last write, so
// back-to-back atoms to one bin all count. the receiver cannot stall the block, so results must
// be taken when done is high.
module periodic_grid_density_histogram import pgdh_pkg::*; #(
  parameter int MAX_BINS_PER_AXIS = 32,
  parameter int COUNT_WIDTH       = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [TIME_W-1:0]   frame_time,
  input  logic [POS_W-1:0]    pos_x,
  input  logic [POS_W-1:0]    pos_y,
  input  logic [POS_W-1:0]    pos_z,
  input  logic [RADDR_W-1:0]  bin_address,
  output logic                done,
  output logic [31:0]         bin_count,
  output logic [FRAMES_W-1:0] frames_used,
  output logic                window_closed
);

  localparam int STORE_DEPTH = MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int NW = $clog2(MAX_BINS_PER_AXIS + 1);
  localparam int IW = (MAX_BINS_PER_AXIS > 1) ? $clog2(MAX_BINS_PER_AXIS) : 1;
  localparam int STAGES = 6;

  cfg_t cfg;

  logic [NW-1:0] n_x, n_y, n_z;
  logic [IW-1:0] ix, iy, iz;

  logic                accept;
  logic                frame_open;
  logic                stopped;
  logic [FRAMES_W-1:0] frame_count;
  logic signed [TIME_W:0] t_ext, lo_lim, hi_lim;

  side_t side_in;
  side_t side [STAGES];

  logic [AW-1:0] t3;
  logic [IW-1:0] iz3;
  logic [AW-1:0] addr4;
  logic [AW-1:0] addr5;

  logic                   clearing;
  logic [AW-1:0]          clr_addr;
  logic                   atom_wr;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;
  logic [31:0]            cur_sat;

  logic                   fwd_valid;
  logic [AW-1:0]          fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  function automatic logic [NW-1:0] eff_bins(input logic [BINS_W-1:0] b);
    if (b == '0) begin
      return NW'(1);
    end else if (32'(b) > 32'(MAX_BINS_PER_AXIS)) begin
      return NW'(MAX_BINS_PER_AXIS);
    end else begin
      return NW'(b);
    end
  endfunction

  pgdh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign n_x = eff_bins(cfg.bins_x);
  assign n_y = eff_bins(cfg.bins_y);
  assign n_z = eff_bins(cfg.bins_z);

  assign busy   = clearing;
  assign accept = start & ~busy;

  // frame header window checks
  assign t_ext  = $signed({frame_time[TIME_W-1], frame_time});
  assign lo_lim = $signed({cfg.window_start[TIME_W-1], cfg.window_start}) - 33'sd1;
  assign hi_lim = $signed({cfg.window_end[TIME_W-1], cfg.window_end}) + 33'sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      stopped     <= 1'b0;
      frame_count <= '0;
    end else if (accept && action == ACT_HEADER) begin
      if (stopped) begin
        frame_open <= 1'b0;
      end else if (t_ext < lo_lim) begin
        frame_open <= 1'b0;
      end else if (cfg.window_end != '0 && t_ext > hi_lim) begin
        stopped    <= 1'b1;
        frame_open <= 1'b0;
      end else begin
        frame_open <= 1'b1;
        if (frame_count != FRAME_MAX) begin
          frame_count <= frame_count + FRAMES_W'(1);
        end
      end
    end
  end

  always_comb begin
    side_in.valid    = accept && ((action == ACT_ATOM && frame_open && !stopped) ||
                                  action == ACT_READ);
    side_in.is_read  = (action == ACT_READ);
    side_in.in_range = 32'(bin_address) < 32'(STORE_DEPTH);
    side_in.raddr    = bin_address;
    side_in.frames   = frame_count;
    side_in.closed   = stopped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        side[i].valid <= 1'b0;
      end
    end else begin
      side[0] <= side_in;
      for (int i = 1; i < STAGES; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  pgdh_axis #(.MAX_BINS_PER_AXIS(MAX_BINS_PER_AXIS)) u_axis_x (
    .clk (clk), .pos ($signed(pos_x)), .scale (cfg.scale_x), .n (n_x), .idx (ix)
  );
  pgdh_axis #(.MAX_BINS_PER_AXIS(MAX_BINS_PER_AXIS)) u_axis_y (
    .clk (clk), .pos ($signed(pos_y)), .scale (cfg.scale_y), .n (n_y), .idx (iy)
  );
  pgdh_axis #(.MAX_BINS_PER_AXIS(MAX_BINS_PER_AXIS)) u_axis_z (
    .clk (clk), .pos ($signed(pos_z)), .scale (cfg.scale_z), .n (n_z), .idx (iz)
  );

  // x-major linear index, one multiply per stage
  always_ff @(posedge clk) begin
    t3    <= AW'(ix) * AW'(n_y) + AW'(iy);
    iz3   <= iz;
    addr4 <= side[3].is_read ? AW'(side[3].raddr) : t3 * AW'(n_z) + AW'(iz3);
    addr5 <= addr4;
  end

  assign atom_wr = side[5].valid && !side[5].is_read;

  // the previous cycle's write is not yet visible in the read data
  assign cur     = (fwd_valid && fwd_addr == addr5) ? fwd_data : rdata;
  assign inc     = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);
  assign cur_sat = (64'(cur) > 64'h0000_0000_FFFF_FFFF) ? '1 : 32'(cur);

  assign ram_we    = clearing | atom_wr;
  assign ram_waddr = clearing ? clr_addr : addr5;
  assign ram_wdata = clearing ? '0 : inc;

  pgdh_bin_ram #(.DEPTH(STORE_DEPTH), .AW(AW), .DW(COUNT_WIDTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr4),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= atom_wr;
    end
    fwd_addr <= addr5;
    fwd_data <= inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side[5].valid && side[5].is_read;
    end
    bin_count     <= side[5].in_range ? cur_sat : '0;
    frames_used   <= side[5].frames;
    window_closed <= side[5].closed;
  end

`ifndef SYNTHESIS
  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(side[5].valid && side[5].is_read))
    else $error("result strobe without a read request in the last stage");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(side[0].valid || side[5].valid || fwd_valid))
    else $error("request in flight during clearing pass");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_frames_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> frame_count >= $past(frame_count))
    else $error("frame count went down");
`endif

endmodule
